// File: rtl/go_to_goal_heading_steering_top_assert.svh
`ifndef GO_TO_GOAL_HEADING_STEERING_TOP_ASSERT_SVH
`define GO_TO_GOAL_HEADING_STEERING_TOP_ASSERT_SVH
// assertion helpers for the steering block
`define GHS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define GHS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: rtl/ghs_pkg.sv
package ghs_pkg;
   localparam int AngW = 22;
   localparam int TabLen = 24;
   localparam logic signed [AngW-1:0] AngPi = 22'sd205887;
   localparam logic signed [AngW-1:0] AngTwoPi = 22'sd411775;
   localparam logic signed [15:0] TurnMax = 16'sd25736;
   localparam logic [23:0] RadiusReset = 24'd98304;
   localparam logic [14:0] SpeedReset = 15'd256;
   localparam logic CsrRadius = 1'b0;
   localparam logic CsrSpeed = 1'b1;

   typedef struct packed {
      logic signed [31:0] own_x;
      logic signed [31:0] own_y;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
   } req_type;

   typedef struct packed {
      logic signed [15:0] turn_rate;
      logic [14:0] linear_speed;
      logic arrived;
   } rsp_type;

   function automatic logic signed [AngW-1:0] atan_entry(input int i);
      logic signed [AngW-1:0] r;
      r = '0;
      unique case (i)
         0: r = 22'sd51472;  1: r = 22'sd30386;  2: r = 22'sd16055;
         3: r = 22'sd8150;   4: r = 22'sd4091;   5: r = 22'sd2047;
         6: r = 22'sd1024;   7: r = 22'sd512;    8: r = 22'sd256;
         9: r = 22'sd128;    10: r = 22'sd64;    11: r = 22'sd32;
         12: r = 22'sd16;    13: r = 22'sd8;     14: r = 22'sd4;
         15: r = 22'sd2;     16: r = 22'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction
endpackage

// File: rtl/go_to_goal_heading_steering_top.sv
// Go-to-goal heading steering.
// Request channel (req_valid/req_stall/req_data) carries robot position,
// orientation quaternion and goal position; response channel
// (rsp_valid/rsp_stall/rsp_data) returns one result per request: turn rate
// (Q3.13), linear speed (Q7.8) and the arrived flag.
// csr_we/csr_index/csr_wdata write the arrival radius and travel speed;
// write only while no request is in flight.
// Accepts one request per cycle unless the output stalls. The pipeline
// is the front end (two stages), the CORDIC rotations (one stage each
// plus an input stage), one stage for the wrap and round, and the output
// register.
// The whole pipeline advances together; while rsp_stall is high with a
// result waiting, req_stall is high and nothing moves, so nothing is lost.
// Reset clears all valid bits and restores radius 1.5 m and speed 1.0.
module go_to_goal_heading_steering_top import ghs_pkg::*; #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [23:0] csr_wdata
);
   localparam int N = (CORDIC_STAGES > TabLen) ? TabLen : CORDIC_STAGES;
   localparam int Depth = N + 5;

   logic [23:0] radius_ff;
   logic [14:0] speed_ff;
   logic [Depth-1:0] vld_ff;
   logic en;
   logic signed [32:0] dx, dy;
   logic signed [35:0] sy, cy;
   logic near;
   logic near_ff [0:N];
   logic signed [AngW-1:0] bearing, yaw;
   logic signed [AngW:0] err_in;
   logic signed [AngW:0] rnd;
   logic signed [15:0] turn_in;
   rsp_type rsp_ff;

   assign en = !(vld_ff[Depth-1] && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RadiusReset;
         speed_ff <= SpeedReset;
         vld_ff <= '0;
      end else begin
         if (csr_we && csr_index == CsrRadius) radius_ff <= csr_wdata;
         if (csr_we && csr_index == CsrSpeed) speed_ff <= csr_wdata[14:0];
         if (en) vld_ff <= {vld_ff[Depth-2:0], req_valid};
      end
   end

   ghs_front u_front (
      .clock, .en, .req(req_data), .radius(radius_ff),
      .dx, .dy, .sy, .cy, .near
   );

   ghs_cordic #(.Stages(N), .DataW(36)) u_bear (
      .clock, .en, .x_in(36'(dx)), .y_in(36'(dy)), .angle(bearing)
   );
   ghs_cordic #(.Stages(N), .DataW(36)) u_yaw (
      .clock, .en, .x_in(cy), .y_in(sy), .angle(yaw)
   );

   always_ff @(posedge clock) begin
      if (en) near_ff[0] <= near;
   end
   for (genvar i = 0; i < N; i++) begin : g_near
      always_ff @(posedge clock) begin
         if (en) near_ff[i+1] <= near_ff[i];
      end
   end

   always_comb begin
      err_in = (AngW+1)'(bearing) - (AngW+1)'(yaw);
      if (err_in > (AngW+1)'(AngPi)) err_in = err_in - (AngW+1)'(AngTwoPi);
      if (err_in < -(AngW+1)'(AngPi)) err_in = err_in + (AngW+1)'(AngTwoPi);
      rnd = (err_in + (AngW+1)'(4)) >>> 3;
      if (rnd > (AngW+1)'(TurnMax)) turn_in = TurnMax;
      else if (rnd < -(AngW+1)'(TurnMax)) turn_in = -TurnMax;
      else turn_in = rnd[15:0];
   end

   logic signed [15:0] turn_ff;
   logic near_o_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         turn_ff <= turn_in;
         near_o_ff <= near_ff[N];
         rsp_ff.turn_rate <= near_o_ff ? 16'sd0 : turn_ff;
         rsp_ff.linear_speed <= near_o_ff ? 15'd0 : speed_ff;
         rsp_ff.arrived <= near_o_ff;
      end
   end

   assign rsp_valid = vld_ff[Depth-1];
   assign rsp_data = rsp_ff;

`include "go_to_goal_heading_steering_top_assert.svh"
   `GHS_ASSERT_IMPL(a_arrived_stop, clock, reset, rsp_valid && rsp_data.arrived,
      rsp_data.turn_rate == 0 && rsp_data.linear_speed == 0, "arrived but moving")
   `GHS_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data), "stalled response changed")
   `GHS_ASSERT_IMPL(a_turn_range, clock, reset, rsp_valid,
      rsp_data.turn_rate <= TurnMax && rsp_data.turn_rate >= -TurnMax, "turn out of range")
endmodule

// File: rtl/ghs_cordic.sv
// pipelined vectoring CORDIC, one stage per rotation, enable shared by all stages
module ghs_cordic import ghs_pkg::*; #(
   parameter int Stages = 16,
   parameter int DataW = 36
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic signed [DataW-1:0] x_in,
   input  logic signed [DataW-1:0] y_in,
   output logic signed [AngW-1:0]  angle
);
   localparam int N = (Stages > TabLen) ? TabLen : Stages;
   logic signed [DataW+1:0] x_ff [0:N];
   logic signed [DataW+1:0] y_ff [0:N];
   logic signed [AngW-1:0]  z_ff [0:N];
   logic zero_ff [0:N];
   logic signed [DataW+1:0] x0_in, y0_in;
   logic signed [AngW-1:0]  z0_in;

   always_comb begin
      x0_in = DataW'(0) + (DataW+2)'(x_in);
      y0_in = (DataW+2)'(y_in);
      z0_in = '0;
      if (x_in < 0) begin
         x0_in = -(DataW+2)'(x_in);
         y0_in = -(DataW+2)'(y_in);
         z0_in = (y_in >= 0) ? AngPi : -AngPi;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= x0_in;
         y_ff[0] <= y0_in;
         z_ff[0] <= z0_in;
         zero_ff[0] <= (x_in == 0) && (y_in == 0);
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            if (y_ff[i] > 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_entry(i);
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_entry(i);
            end
         end
      end
   end

   assign angle = zero_ff[N] ? '0 : z_ff[N];
endmodule

// File: rtl/ghs_front.sv
// two-stage front end: differences, quaternion products, distance compare
module ghs_front import ghs_pkg::*; (
   input  logic                clock,
   input  logic                en,
   input  req_type             req,
   input  logic [23:0]         radius,
   output logic signed [32:0]  dx,
   output logic signed [32:0]  dy,
   output logic signed [35:0]  sy,
   output logic signed [35:0]  cy,
   output logic                near
);
   logic signed [32:0] dx_ff, dy_ff;
   logic signed [31:0] wz_ff, xy_ff, yy_ff, zz_ff;
   logic [47:0] r2_ff;
   logic signed [32:0] dx2_ff, dy2_ff;
   logic signed [35:0] sy_ff, cy_ff;
   logic [47:0] d2a_ff, d2b_ff, r2b_ff;
   logic inr_ff, inr2_ff;
   logic signed [32:0] dx_in, dy_in;
   logic inr_in;
   logic signed [49:0] dxsq_in, dysq_in;

   assign dx_in = 33'(req.target_x) - 33'(req.own_x);
   assign dy_in = 33'(req.target_y) - 33'(req.own_y);
   assign inr_in = (dx_in > -33'sd16777216) && (dx_in < 33'sd16777216)
                && (dy_in > -33'sd16777216) && (dy_in < 33'sd16777216);

   // only meaningful when in range, then the 25-bit slice holds the whole value
   assign dxsq_in = 25'(dx_ff) * 25'(dx_ff);
   assign dysq_in = 25'(dy_ff) * 25'(dy_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         inr_ff <= inr_in;
         wz_ff <= req.quat_w * req.quat_z;
         xy_ff <= req.quat_x * req.quat_y;
         yy_ff <= req.quat_y * req.quat_y;
         zz_ff <= req.quat_z * req.quat_z;
         r2_ff <= radius * radius;
         // stage 2: squares of the 25-bit differences
         dx2_ff <= dx_ff;
         dy2_ff <= dy_ff;
         inr2_ff <= inr_ff;
         d2a_ff <= dxsq_in[47:0];
         d2b_ff <= dysq_in[47:0];
         r2b_ff <= r2_ff;
         sy_ff <= 36'sd2 * (36'(wz_ff) + 36'(xy_ff));
         cy_ff <= (36'sd1 <<< 28) - 36'sd2 * (36'(yy_ff) + 36'(zz_ff));
      end
   end

   assign dx = dx2_ff;
   assign dy = dy2_ff;
   assign sy = sy_ff;
   assign cy = cy_ff;
   assign near = inr2_ff && ((49'(d2a_ff) + 49'(d2b_ff)) < 49'(r2b_ff));
endmodule
